[rtl/core/crc_generate_and_check_defines.svh]
// assertion macros for the crc generate and check rtl
`ifndef CRC_GENERATE_AND_CHECK_DEFINES_SVH
`define CRC_GENERATE_AND_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// implication checked on every rising clock edge outside reset
`define CRCGC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("crcgc assertion failed");
// implication checked on every rising clock edge, reset included
`define CRCGC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("crcgc assertion failed");
`else
`define CRCGC_ASSERT(label, clk, rst, prop)
`define CRCGC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/core/crcgc_pkg.sv]
// shared types, constants and register indexes of the crc generate and check block
package crcgc_pkg;

   localparam int MAX_DEGREE = 32;
   localparam int REM_W      = 32;
   localparam int GEN_W      = 32;
   localparam int DEG_W      = 6;
   localparam int IDX_W      = $clog2(MAX_DEGREE);
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [DEG_W-1:0] MAX_DEG_CODE = DEG_W'(MAX_DEGREE);
   localparam logic [DEG_W-1:0] MIN_DEG_CODE = DEG_W'(1);

   localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(32'h0000_1021);
   localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(16);

   typedef enum logic {
      OP_GENERATE = 1'b0,
      OP_CHECK    = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GENERATOR_LOW_BITS = 8'd0,
      REG_DEGREE             = 8'd1
   } reg_idx_type;

   typedef struct packed {
      logic [GEN_W-1:0] generator_low_bits;
      logic [DEG_W-1:0] degree;
   } cfg_type;

endpackage

[rtl/core/crcgc_if.sv]
// valid/ready channel interfaces for request, response and register writes
interface crcgc_req_if import crcgc_pkg::*; ();
   logic valid;
   logic ready;
   logic operation;
   logic data_bit;
   logic last;

   modport source (output valid, output operation, output data_bit, output last,
                   input ready);
   modport sink (input valid, input operation, input data_bit, input last,
                 output ready);
endinterface

interface crcgc_rsp_if import crcgc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REM_W-1:0] remainder;
   logic             error;

   modport source (output valid, output remainder, output error, input ready);
   modport sink (input valid, input remainder, input error, output ready);
endinterface

interface crcgc_csr_if import crcgc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/crcgc_csr.sv]
// configuration registers: generator low bits and degree
module crcgc_csr import crcgc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   crcgc_csr_if.sink      csr_if,
   output cfg_type        cfg
);

   logic [GEN_W-1:0] gen_ff;
   logic [GEN_W-1:0] gen_in;
   logic [DEG_W-1:0] deg_ff;
   logic [DEG_W-1:0] deg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      gen_in = gen_ff;
      deg_in = deg_ff;
      if (csr_if.valid) begin
         case (reg_idx_type'(csr_if.index))
            REG_GENERATOR_LOW_BITS: gen_in = csr_if.data[GEN_W-1:0];
            REG_DEGREE:             deg_in = csr_if.data[DEG_W-1:0];
            default:                ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_RESET;
         deg_ff <= DEG_RESET;
      end else begin
         gen_ff <= gen_in;
         deg_ff <= deg_in;
      end
   end

   assign cfg.generator_low_bits = gen_ff;
   assign cfg.degree             = deg_ff;

endmodule

[rtl/core/crcgc_step.sv]
// one shift and conditional xor of the crc division for a single bit
module crcgc_step import crcgc_pkg::*; (
   input  cfg_type          cfg,
   input  logic [REM_W-1:0] part_rem,
   input  op_type           op,
   input  logic             data_bit,
   output logic [REM_W-1:0] next_rem,
   output logic             check_error
);

   logic [DEG_W-1:0] deg_eff;
   logic [REM_W-1:0] mask;
   logic [REM_W-1:0] rem_m;
   logic [REM_W-1:0] poly;
   logic [REM_W-1:0] shifted;
   logic [IDX_W-1:0] top_idx;
   logic             top;
   logic             fb;

   // degree zero acts as one, large degrees saturate
   always_comb begin
      if (cfg.degree < MIN_DEG_CODE) begin
         deg_eff = MIN_DEG_CODE;
      end else if (cfg.degree > MAX_DEG_CODE) begin
         deg_eff = MAX_DEG_CODE;
      end else begin
         deg_eff = cfg.degree;
      end
   end

   always_comb begin
      for (int i = 0; i < REM_W; i++) begin
         mask[i] = (DEG_W'(i) < deg_eff);
      end
   end

   assign rem_m   = part_rem & mask;
   assign poly    = cfg.generator_low_bits[REM_W-1:0] & mask;
   assign top_idx = IDX_W'(deg_eff - MIN_DEG_CODE);
   assign top     = rem_m[top_idx];

   always_comb begin
      case (op)
         OP_GENERATE: begin
            // augmented form: incoming bit folds into the feedback
            fb      = top ^ data_bit;
            shifted = {rem_m[REM_W-2:0], 1'b0} & mask;
         end
         OP_CHECK: begin
            fb      = top;
            shifted = {rem_m[REM_W-2:0], data_bit} & mask;
         end
         default: begin
            fb      = 1'b0;
            shifted = '0;
         end
      endcase
   end

   assign next_rem    = fb ? (shifted ^ poly) : shifted;
   assign check_error = (op == OP_CHECK) && (next_rem != '0);

endmodule

[rtl/core/crc_generate_and_check.sv]
// Bit-serial CRC generator and checker with a programmable generator polynomial.
// req_if carries one bit per request: operation (0 generate, 1 check), data_bit
// (most significant first) and last. A request with last set yields one response
// on rsp_if: the degree-bit remainder and, in check mode, error when it is nonzero.
// The running remainder then clears for the next message or frame.
// csr_if writes register 0 (generator bits below the implied top term) and
// register 1 (degree, 0 treated as 1, above 32 treated as 32); write only while idle.
// A request is registered in the input register, then stepped into the remainder;
// for a last bit, the remainder and error go into the response register, which
// drives rsp_if. Throughput: one bit per cycle, set by the single shift-and-xor step,
// except while a last bit waits as described next.
// A bit without last never stalls in the input register; a last bit waits there
// while a previous response is still held because rsp_if.ready is low, and
// req_if.ready stays low for as long as it waits.
// Reset (synchronous, active high) clears the remainder, drops both pipeline
// valids and loads generator 0x1021 and degree 16.
`include "crc_generate_and_check_defines.svh"

module crc_generate_and_check import crcgc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   crcgc_req_if.sink   req_if,
   crcgc_rsp_if.source rsp_if,
   crcgc_csr_if.sink   csr_if
);

   cfg_type          cfg;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   op_type           s1_op_ff;
   logic             s1_bit_ff;
   logic             s1_last_ff;
   logic [REM_W-1:0] part_ff;
   logic [REM_W-1:0] part_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [REM_W-1:0] rsp_rem_ff;
   logic             rsp_err_ff;

   logic [REM_W-1:0] step_rem;
   logic             step_err;
   logic             s1_move;
   logic             req_fire;
   logic             rsp_free;

   crcgc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   crcgc_step u_step (
      .cfg         (cfg),
      .part_rem    (part_ff),
      .op          (s1_op_ff),
      .data_bit    (s1_bit_ff),
      .next_rem    (step_rem),
      .check_error (step_err)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_move      = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_valid_ff && !s1_move);
      part_in      = part_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (s1_move) begin
         // a finished message or frame leaves the remainder cleared
         part_in = s1_last_ff ? '0 : step_rem;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         part_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         part_ff      <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= op_type'(req_if.operation);
         s1_bit_ff  <= req_if.data_bit;
         s1_last_ff <= req_if.last;
      end
      if (s1_move && s1_last_ff) begin
         rsp_rem_ff <= step_rem;
         rsp_err_ff <= step_err;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.remainder = rsp_rem_ff;
   assign rsp_if.error     = rsp_err_ff;

   `CRCGC_ASSERT(a_clear_after_last, clock, reset,
      (s1_move && s1_last_ff) |=> (part_ff == '0))
   `CRCGC_ASSERT(a_error_nonzero, clock, reset,
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_rem_ff != '0))
   `CRCGC_ASSERT(a_mid_bits_flow, clock, reset,
      (s1_valid_ff && !s1_last_ff) |-> s1_move)
   `CRCGC_ASSERT(a_request_staged, clock, reset,
      req_fire |=> s1_valid_ff)
   `CRCGC_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!s1_valid_ff && !rsp_valid_ff && (part_ff == '0)))

endmodule

[tb/sv/crc_generate_and_check_test.sv]
// self-checking testbench for the bit-serial crc generate and check block
`timescale 1ns / 100ps

module crc_generate_and_check_test;
   import crcgc_pkg::*;

   typedef struct packed {
      logic [REM_W-1:0] remainder;
      logic             error;
   } crc_result_type;

   typedef bit bit_q_type[$];

   class crc_scoreboard;
      logic [GEN_W-1:0] gen_bits;
      logic [DEG_W-1:0] deg_code;
      logic [REM_W-1:0] running_rem;
      crc_result_type   expected_crcs[$];
      int               errors;

      function new();
         gen_bits    = GEN_RESET;
         deg_code    = DEG_RESET;
         running_rem = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_GENERATOR_LOW_BITS) begin
            gen_bits = data[GEN_W-1:0];
         end else if (idx == REG_DEGREE) begin
            deg_code = data[DEG_W-1:0];
         end
      endfunction

      // degree code saturates into 1..MAX_DEGREE
      function int unsigned eff_degree();
         if (deg_code < MIN_DEG_CODE) return 1;
         if (deg_code > MAX_DEG_CODE) return MAX_DEGREE;
         return deg_code;
      endfunction

      function logic [REM_W-1:0] rem_mask();
         logic [63:0] m;
         m = (64'd1 << eff_degree()) - 64'd1;
         return m[REM_W-1:0];
      endfunction

      // one division step, augmented in generate mode, plain in check mode
      function logic [REM_W-1:0] shift_in(logic [REM_W-1:0] r, op_type op, logic b);
         int unsigned      d;
         logic [REM_W-1:0] m;
         logic             fb;
         d  = eff_degree();
         m  = rem_mask();
         r  = r & m;
         fb = r[d-1] ^ ((op == OP_GENERATE) ? b : 1'b0);
         r  = ((r << 1) | {{(REM_W-1){1'b0}}, (op == OP_CHECK) & b}) & m;
         if (fb) r = r ^ (gen_bits & m);
         return r;
      endfunction

      function logic [REM_W-1:0] crc_of(bit_q_type msg);
         logic [REM_W-1:0] r;
         r = '0;
         foreach (msg[i]) r = shift_in(r, OP_GENERATE, msg[i]);
         return r;
      endfunction

      function void note_request(op_type op, logic b, logic l);
         crc_result_type res;
         running_rem = shift_in(running_rem, op, b);
         if (l) begin
            res.remainder = running_rem;
            res.error     = (op == OP_CHECK) && (running_rem != '0);
            expected_crcs.push_back(res);
            running_rem = '0;
         end
      endfunction

      function void check_response(logic [REM_W-1:0] rem, logic err);
         crc_result_type want;
         if (expected_crcs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: remainder %h error %b", rem, err);
            return;
         end
         want = expected_crcs.pop_front();
         if (rem !== want.remainder || err !== want.error) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: remainder exp %h got %h, error exp %b got %b",
                        want.remainder, rem, want.error, err);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   crcgc_req_if req_if ();
   crcgc_rsp_if rsp_if ();
   crcgc_csr_if csr_if ();

   crc_generate_and_check u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   crc_scoreboard sb;
   int            req_idle_pct;
   int            rsp_idle_pct;
   int            rsp_hold_left = 0;
   int            items_sent    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random back-pressure plus long hold-off when requested
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) sb.write_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            sb.note_request(op_type'(req_if.operation), req_if.data_bit, req_if.last);
         if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.remainder, rsp_if.error);
      end
   end

   task automatic send_bit(op_type op, logic b, logic l);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.operation = op;
      req_if.data_bit  = b;
      req_if.last      = l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_frame(op_type op, bit_q_type bits);
      foreach (bits[i]) send_bit(op, bits[i], i == bits.size() - 1);
   endtask

   // message with its generated crc, then the frame carrying it, maybe with one bit flipped
   task automatic send_pair(bit_q_type msg, bit corrupt);
      bit_q_type        frame;
      logic [REM_W-1:0] crc;
      int               idx;
      crc   = sb.crc_of(msg);
      send_frame(OP_GENERATE, msg);
      frame = msg;
      for (int i = sb.eff_degree() - 1; i >= 0; i--) frame.push_back(crc[i]);
      if (corrupt) begin
         idx        = $urandom_range(frame.size() - 1);
         frame[idx] = !frame[idx];
      end
      send_frame(OP_CHECK, frame);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // stop requests, wait for every response, then let the pipeline settle
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (sb.expected_crcs.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_config(int kind);
      logic [DEG_W-1:0]      deg;
      logic [CSR_DATA_W-1:0] deg_data;
      logic [CSR_DATA_W-1:0] gen;
      gen = $urandom;
      case (kind)
         0: deg = MAX_DEG_CODE;
         1: deg = MIN_DEG_CODE;
         2: deg = DEG_W'($urandom_range(63));
         default: deg = DEG_W'($urandom_range(MAX_DEGREE, 1));
      endcase
      deg_data             = $urandom;
      deg_data[DEG_W-1:0]  = deg;
      wait_idle();
      if ($urandom_range(1)) begin
         write_csr(REG_DEGREE, deg_data);
         write_csr(REG_GENERATOR_LOW_BITS, gen);
      end else begin
         write_csr(REG_GENERATOR_LOW_BITS, gen);
         write_csr(REG_DEGREE, deg_data);
      end
      if ($urandom_range(2) == 0) write_csr(CSR_IDX_W'($urandom_range(255, 2)), $urandom);
   endtask

   task automatic send_random_frame();
      bit_q_type   msg;
      int unsigned kind;
      int unsigned len;
      kind = $urandom_range(99);
      len  = $urandom_range(12, 1);
      if (kind < 60) begin
         for (int i = 0; i < len; i++) msg.push_back(1'($urandom_range(1)));
         send_pair(msg, $urandom_range(3) == 0);
      end else if (kind < 80) begin
         for (int i = 0; i < len; i++)
            send_bit(op_type'(1'($urandom_range(1))), 1'($urandom_range(1)), i == len - 1);
      end else begin
         // noise: random ops with scattered last bits
         for (int i = 0; i < len; i++)
            send_bit(op_type'(1'($urandom_range(1))), 1'($urandom_range(1)),
                     (i == len - 1) || ($urandom_range(3) == 0));
      end
   endtask

   initial begin
      int target;
      sb               = new();
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_GENERATE;
      req_if.data_bit  = 1'b0;
      req_if.last      = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      req_idle_pct     = 30;
      rsp_idle_pct     = 76;
      target           = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset polynomial, single-bit messages and frames
      send_bit(OP_GENERATE, 1'b0, 1'b1);
      send_bit(OP_GENERATE, 1'b1, 1'b1);
      send_bit(OP_CHECK, 1'b1, 1'b1);
      send_bit(OP_CHECK, 1'b0, 1'b1);
      // operation switched inside one frame
      send_bit(OP_GENERATE, 1'b1, 1'b0);
      send_bit(OP_CHECK, 1'b1, 1'b0);
      send_bit(OP_GENERATE, 1'b0, 1'b1);
      send_bit(OP_GENERATE, 1'b1, 1'b0);
      send_bit(OP_CHECK, 1'b1, 1'b1);

      // degree code above the maximum, all generator bits set
      wait_idle();
      write_csr(REG_DEGREE, 32'hFFFF_FFFF);
      write_csr(REG_GENERATOR_LOW_BITS, 32'hFFFF_FFFF);
      send_bit(OP_GENERATE, 1'b1, 1'b1);
      send_bit(OP_CHECK, 1'b1, 1'b1);
      send_bit(OP_GENERATE, 1'b1, 1'b0);

      // degree code zero while a partial remainder is still held
      wait_idle();
      write_csr(REG_DEGREE, 32'hFFFF_FFC0);
      write_csr(REG_GENERATOR_LOW_BITS, 32'h0000_0001);
      send_bit(OP_GENERATE, 1'b1, 1'b1);
      send_bit(OP_CHECK, 1'b1, 1'b1);

      // generator bits above degree four are ignored, unknown index too
      wait_idle();
      write_csr(REG_DEGREE, 32'h0000_0004);
      write_csr(REG_GENERATOR_LOW_BITS, 32'hFFFF_FFF3);
      write_csr(8'hFF, $urandom);
      send_pair('{1'b1, 1'b1}, 1'b0);

      // full degree with an empty generator
      wait_idle();
      write_csr(REG_DEGREE, MAX_DEGREE);
      write_csr(REG_GENERATOR_LOW_BITS, 32'h0);
      send_bit(OP_CHECK, 1'b1, 1'b1);
      send_bit(OP_GENERATE, 1'b1, 1'b1);

      target = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 30;
               rsp_idle_pct = 76;
            end
            1: begin
               req_idle_pct = 76;
               rsp_idle_pct = 30;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int chunk = 0; chunk < 4; chunk++) begin
            program_config(chunk);
            // long receiver hold-off so the input side backs up
            if (phase == 2 && chunk == 0) rsp_hold_left = 300;
            target += 108;
            while (items_sent < target) send_random_frame();
         end
      end
      req_if.valid = 1'b0;

      for (int n = 0; n < 20000 && sb.expected_crcs.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.expected_crcs.size() != 0) begin
         $display("%0d responses never arrived", sb.expected_crcs.size());
         sb.errors += sb.expected_crcs.size();
      end
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
